[rtl/can_error_flood_guard_assert.svh]
// Assertion helpers for the CAN error flood guard.
// Each macro checks a property on the rising edge of clk while rst_n is high.
`ifndef CAN_ERROR_FLOOD_GUARD_ASSERT_SVH
`define CAN_ERROR_FLOOD_GUARD_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CEFG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flood guard check failed");

// The consequent must hold in the cycle after the antecedent.
`define CEFG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flood guard check failed");

`endif

[rtl/cefg_pkg.sv]
`default_nettype none

package cefg_pkg;

  // Bus state codes carried by the event word.
  localparam logic [2:0] BUS_ACTIVE  = 3'd0;
  localparam logic [2:0] BUS_WARNING = 3'd1;
  localparam logic [2:0] BUS_PASSIVE = 3'd2;
  localparam logic [2:0] BUS_OFF     = 3'd3;
  localparam logic [2:0] BUS_STOPPED = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WINDOW_MS       = 2'd0;
  localparam logic [1:0] CFG_FLOOD_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_PASSIVE_LIMIT   = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] WINDOW_MS_RST       = 16'd1000;
  localparam logic [15:0] FLOOD_THRESHOLD_RST = 16'd100;
  localparam logic [15:0] PASSIVE_LIMIT_RST   = 16'd10;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // CAN lamp commands.
  typedef enum logic [2:0] {
    LAMP_NONE    = 3'd0,
    LAMP_ACTIVE  = 3'd1,
    LAMP_WARNING = 3'd2,
    LAMP_ERROR   = 3'd3,
    LAMP_OFF     = 3'd4
  } lamp_t;

  typedef struct packed {
    logic [15:0] window_ms;
    logic [15:0] flood_threshold;
    logic [15:0] passive_limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0] window_start;
    logic [15:0] error_event_count;
    logic        throttled;
    logic        forced_off;
    logic [15:0] passive_event_count;
  } guard_state_t;

  typedef struct packed {
    logic  stop_request;
    logic  usb_lamp;
    lamp_t can_lamp;
    logic  throttle_flag;
  } guard_result_t;

  // Counter increment that sticks at the top value.
  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

endpackage

`default_nettype wire

[rtl/cefg_in_if.sv]
`default_nettype none

// Event channel: one bus state change with its timestamp per word.
interface cefg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  bus_state;
  logic [31:0] now_ms;

  modport source (output valid, output bus_state, output now_ms, input ready);
  modport sink (input valid, input bus_state, input now_ms, output ready);
endinterface

`default_nettype wire

[rtl/cefg_out_if.sv]
`default_nettype none

// Result channel: stop request and lamp commands for one event per word.
interface cefg_out_if;
  logic       valid;
  logic       ready;
  logic       stop_request;
  logic       usb_lamp;
  logic [2:0] can_lamp;
  logic       throttle_flag;

  modport source (output valid, output stop_request, output usb_lamp,
                  output can_lamp, output throttle_flag, input ready);
  modport sink (input valid, input stop_request, input usb_lamp,
                input can_lamp, input throttle_flag, output ready);
endinterface

`default_nettype wire

[rtl/can_error_flood_guard.sv]
`default_nettype none

// CAN error flood guard.
// in_ch carries one controller state-change word per item: bus_state and a
// wrapping millisecond timestamp now_ms. out_ch returns exactly one word per
// event: stop_request, usb_lamp, the final can_lamp command and the
// throttle flag after the event. Both channels use valid/ready and a word
// moves at a rising edge with both high.
// The whole update (window check, counting, flood and per-state handling)
// is one pass of logic from the guard state and the incoming word into the
// state registers and the output register, so a result is valid in the cycle
// after its event is taken, and one event is taken every cycle while the receiver does not stall.
// The output register holds a finished word while the receiver stalls; a new
// event is still taken in the cycle the held word leaves, so a stall costs
// only the cycles during which out_ch.ready is low.
// cfg_we writes cfg_wdata into the register chosen by cfg_index
// (0 window_ms, 1 flood_threshold, 2 passive_limit); other indexes are ignored.
// Synchronous reset loads the register defaults (1000, 100, 10), clears the
// guard state and empties the output register.
module can_error_flood_guard import cefg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  cefg_in_if.sink          in_ch,
  cefg_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  cfg_t          cfg;
  guard_state_t  state_r;
  guard_state_t  state_nxt;
  guard_result_t res_nxt;
  guard_result_t res_r;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic          in_accept;

  cefg_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  cefg_update u_update (
    .cur       (state_r),
    .cfg       (cfg),
    .bus_state (in_ch.bus_state),
    .now_ms    (in_ch.now_ms),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  // Take a word whenever the output register is empty or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Guard state advances only on an accepted event.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        state_r <= state_nxt;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.stop_request  = res_r.stop_request;
  assign out_ch.usb_lamp      = res_r.usb_lamp;
  assign out_ch.can_lamp      = res_r.can_lamp;
  assign out_ch.throttle_flag = res_r.throttle_flag;

  `include "can_error_flood_guard_assert.svh"

  // A held stop request always matches a forced-off controller.
  `CEFG_ASSERT_NOW(a_stop_forced, out_valid_r && res_r.stop_request, state_r.forced_off)
  // The reported throttle flag is the throttle state left by the last event.
  `CEFG_ASSERT_NOW(a_thr_state, out_valid_r, res_r.throttle_flag == state_r.throttled)
  // A USB error command always comes with some CAN lamp command.
  `CEFG_ASSERT_NOW(a_usb_lamp, out_valid_r && res_r.usb_lamp, res_r.can_lamp != LAMP_NONE)
  // Every accepted event leaves a word in the output register.
  `CEFG_ASSERT_NEXT(a_accept_out, in_accept, out_valid_r)

endmodule

`default_nettype wire

[rtl/cefg_cfg_regs.sv]
`default_nettype none

module cefg_cfg_regs import cefg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        we,
  input  wire logic [1:0]  index,
  input  wire logic [15:0] wdata,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index; writes to unused indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      case (index)
        CFG_WINDOW_MS:       cfg_nxt.window_ms       = wdata;
        CFG_FLOOD_THRESHOLD: cfg_nxt.flood_threshold = wdata;
        CFG_PASSIVE_LIMIT:   cfg_nxt.passive_limit   = wdata;
        default:             cfg_nxt                 = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ms       <= WINDOW_MS_RST;
      cfg_r.flood_threshold <= FLOOD_THRESHOLD_RST;
      cfg_r.passive_limit   <= PASSIVE_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[rtl/cefg_update.sv]
`default_nettype none

module cefg_update import cefg_pkg::*; (
  input  wire guard_state_t  cur,
  input  wire cfg_t          cfg,
  input  wire logic [2:0]    bus_state,
  input  wire logic [31:0]   now_ms,
  output guard_state_t       nxt,
  output guard_result_t      res
);

  logic [31:0] elapsed;
  logic        expire;
  logic [15:0] err_cnt;
  logic        flood;
  logic        done;
  logic [15:0] passive_inc;

  always_comb begin
    nxt = cur;
    res.stop_request  = 1'b0;
    res.usb_lamp      = 1'b0;
    res.can_lamp      = LAMP_NONE;
    res.throttle_flag = 1'b0;

    // Window expiry: the wrapping distance from the window start.
    elapsed = now_ms - cur.window_start;
    expire  = elapsed > {16'd0, cfg.window_ms};
    if (expire) begin
      nxt.error_event_count = 16'd0;
      nxt.window_start      = now_ms;
      nxt.throttled         = 1'b0;
    end

    // Every state other than error active counts as an error event.
    err_cnt = nxt.error_event_count;
    if (bus_state != BUS_ACTIVE) begin
      err_cnt = sat_inc16(err_cnt);
    end
    nxt.error_event_count = err_cnt;

    // Flood: throttle the lamps once and force the controller off once.
    flood = err_cnt > cfg.flood_threshold;
    done  = 1'b0;
    if (flood) begin
      if (!nxt.throttled) begin
        nxt.throttled = 1'b1;
        res.usb_lamp  = 1'b1;
        res.can_lamp  = LAMP_ERROR;
      end
      if (!cur.forced_off) begin
        nxt.forced_off   = 1'b1;
        res.stop_request = 1'b1;
        done             = 1'b1;
      end
    end

    // Per-state handling, skipped when the flood already stopped the bus.
    passive_inc = sat_inc16(cur.passive_event_count);
    if (!done) begin
      case (bus_state)
        BUS_ACTIVE: begin
          nxt.passive_event_count = 16'd0;
          nxt.forced_off          = 1'b0;
          res.can_lamp            = LAMP_ACTIVE;
        end
        BUS_WARNING: begin
          res.can_lamp = LAMP_WARNING;
        end
        BUS_PASSIVE: begin
          nxt.passive_event_count = passive_inc;
          res.can_lamp            = LAMP_ERROR;
          if (passive_inc > cfg.passive_limit) begin
            res.stop_request = 1'b1;
            nxt.forced_off   = 1'b1;
            res.usb_lamp     = 1'b1;
            res.can_lamp     = LAMP_OFF;
          end
        end
        BUS_OFF: begin
          nxt.forced_off = 1'b1;
          res.usb_lamp   = 1'b1;
          res.can_lamp   = LAMP_OFF;
        end
        BUS_STOPPED: begin
          res.can_lamp = LAMP_OFF;
        end
        default: begin
          // Unknown states only take part in the flood count.
          res.can_lamp = res.can_lamp;
        end
      endcase
    end

    res.throttle_flag = nxt.throttled;
  end

endmodule

`default_nettype wire
